@@ hdl/wtpz_pkg.sv @@
// ----------------------------------------------------------------------------
// wtpz_pkg
// shared types, codes and constants of the wheel tap pan/zoom controller
// ----------------------------------------------------------------------------
`default_nettype none

package wtpz_pkg;

  // field widths
  localparam int KIND_W     = 3;
  localparam int POS_W      = 8;
  localparam int NOW_W      = 32;
  localparam int STEPS_W    = 4;
  localparam int OPEN_W     = 10;
  localparam int PAN_W      = 16;
  localparam int ZOOM_OUT_W = 10;
  localparam int ZOOM_W     = 11;
  localparam int START_W    = 7;
  localparam int DEV_W      = 6;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WINDOW_W    = 16;
  localparam int THRESH_W    = 6;
  localparam int STEP_W      = 10;

  // configuration reset values
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = '0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(4);
  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(32);

  // zoom arithmetic: z = (z * 104 or 96 + 50) / 100, clamp 100..500
  localparam int ZOOM_MIN      = 100;
  localparam int ZOOM_MAX      = 500;
  localparam int ZOOM_OPEN_MAX = 1000;
  localparam int ZOOM_IN_MUL   = 104;
  localparam int ZOOM_OUT_MUL  = 96;
  localparam int ZOOM_ROUND    = 50;
  localparam int SCALED_W      = 18;
  // exact floor(x / 100) for x < 2^18: (x * RECIP) >> RECIP_SHIFT
  localparam int RECIP         = 335545;
  localparam int RECIP_W       = 19;
  localparam int RECIP_SHIFT   = 25;
  localparam int PROD_W        = SCALED_W + RECIP_W;

  // wheel geometry
  localparam int WHEEL_SIZE = 96;
  localparam int WHEEL_HALF = 48;
  localparam int QUAD_SPAN  = 24;
  localparam int QUAD_HALF  = 12;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WHEEL  = 3'd0,
    KIND_DIR    = 3'd1,
    KIND_ZOOM   = 3'd2,
    KIND_OPEN   = 3'd3,
    KIND_TAKE   = 3'd4,
    KIND_CANCEL = 3'd5
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RECENT_WINDOW = 2'd0,
    REG_TAP_LIMIT     = 2'd1,
    REG_PAN_STRIDE    = 2'd2
  } reg_index_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               touched;
    logic [POS_W-1:0]   wheel_position;
    logic [NOW_W-1:0]   now;
    logic               zoom_up;
    logic [STEPS_W-1:0] zoom_steps;
    logic [OPEN_W-1:0]  open_zoom;
  } in_item_t;

  typedef struct packed {
    logic signed [PAN_W-1:0] pan_x_out;
    logic signed [PAN_W-1:0] pan_y_out;
    logic [ZOOM_OUT_W-1:0]   zoom_out;
    logic                    zoomed;
    logic                    render_pending;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic apply;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_pending;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hdl/wheel_tap_pan_zoom_control.sv @@
// ----------------------------------------------------------------------------
// wheel_tap_pan_zoom_control
// accepts one transaction at a time; a zoom adjust of n steps runs each step
// through the shared scale/divide step unit, scaling in ST_STEP and dividing
// in ST_DIV, before ST_APPLY writes the result. a new transaction is taken
// only after ST_APPLY, which waits while a finished result is not yet taken.
// reset (synchronous) restores config defaults, zoom 100, zero pan, no touch.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_tap_pan_zoom_control (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire wtpz_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output wtpz_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [wtpz_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [wtpz_pkg::CFG_DATA_W-1:0]   cfg_data
);

  wtpz_pkg::ctl_cmd_t   cmd;
  wtpz_pkg::dp_status_t status;

  wtpz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wtpz_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // reported zoom stays within the open-detail range
  a_zoom_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.zoom_out >= 10'd100) && (out_data.zoom_out <= 10'd1000))
    else $error("zoom out of range");

  // zoomed flag agrees with the reported zoom
  a_zoomed_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.zoomed == (out_data.zoom_out > 10'd100)))
    else $error("zoomed flag mismatch");

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // one transaction at a time: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

`default_nettype wire

@@ hdl/wtpz_ctrl.sv @@
// ----------------------------------------------------------------------------
// wtpz_ctrl
// item sequencer: accept, zoom step loop, apply and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module wtpz_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire wtpz_pkg::dp_status_t  status,
  output wtpz_pkg::ctl_cmd_t         cmd
);

  wtpz_pkg::state_t state;
  wtpz_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtpz_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wtpz_pkg::ST_IDLE: begin
        if (in_valid) state_next = wtpz_pkg::ST_STEP;
      end
      wtpz_pkg::ST_STEP: begin
        if (status.step_pending) state_next = wtpz_pkg::ST_DIV;
        else                     state_next = wtpz_pkg::ST_APPLY;
      end
      wtpz_pkg::ST_DIV: begin
        state_next = wtpz_pkg::ST_STEP;
      end
      wtpz_pkg::ST_APPLY: begin
        if (!status.out_busy) state_next = wtpz_pkg::ST_IDLE;
      end
      default: state_next = wtpz_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      wtpz_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      wtpz_pkg::ST_STEP: begin
        cmd.mul = status.step_pending;
      end
      wtpz_pkg::ST_DIV: begin
        cmd.div = 1'b1;
      end
      wtpz_pkg::ST_APPLY: begin
        cmd.apply = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/wtpz_datapath.sv @@
// ----------------------------------------------------------------------------
// wtpz_datapath
// viewport and touch state, zoom step unit, config registers, result register
// ----------------------------------------------------------------------------
`default_nettype none

module wtpz_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire wtpz_pkg::ctl_cmd_t                    cmd,
  output wtpz_pkg::dp_status_t                       status,
  input  wire wtpz_pkg::in_item_t                    in_data,
  input  wire logic                                  cfg_we,
  input  wire logic [wtpz_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [wtpz_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  out_ready,
  output logic                                       out_valid,
  output wtpz_pkg::out_item_t                        out_data
);

  localparam int PW = wtpz_pkg::PAN_W;
  localparam int ZW = wtpz_pkg::ZOOM_W;
  localparam int SW = wtpz_pkg::START_W;
  localparam int DW = wtpz_pkg::DEV_W;

  // saturating pan move by one step
  function automatic logic signed [PW-1:0] pan_move(
    input logic signed [PW-1:0]           p,
    input logic [wtpz_pkg::STEP_W-1:0]    s,
    input logic                           neg
  );
    logic signed [PW:0] ext;
    logic signed [PW:0] stp;
    logic signed [PW:0] sum;
    ext = {p[PW-1], p};
    stp = $signed({{(PW+1-wtpz_pkg::STEP_W){1'b0}}, s});
    sum = neg ? (ext - stp) : (ext + stp);
    if (sum > $signed((PW+1)'(2**(PW-1) - 1)))
      return {1'b0, {(PW-1){1'b1}}};
    else if (sum < -$signed((PW+1)'(2**(PW-1))))
      return {1'b1, {(PW-1){1'b0}}};
    else
      return sum[PW-1:0];
  endfunction

  // configuration registers
  logic [wtpz_pkg::WINDOW_W-1:0] recent_window;
  logic [wtpz_pkg::THRESH_W-1:0] tap_limit;
  logic [wtpz_pkg::STEP_W-1:0]   pan_stride;

  // architectural state
  logic signed [PW-1:0]       pan_x, pan_y;
  logic [ZW-1:0]              zoom_level;
  logic                       touch_active, start_valid;
  logic [SW-1:0]              touch_start;
  logic [DW-1:0]              touch_max_dev;
  logic [wtpz_pkg::NOW_W-1:0] direction_tick;
  logic                       pan_render_flag;

  logic signed [PW-1:0]       pan_x_next, pan_y_next;
  logic [ZW-1:0]              zoom_level_next;
  logic                       touch_active_next, start_valid_next;
  logic [SW-1:0]              touch_start_next;
  logic [DW-1:0]              touch_max_dev_next;
  logic [wtpz_pkg::NOW_W-1:0] direction_tick_next;
  logic                       pan_render_flag_next;

  // working registers
  wtpz_pkg::in_item_t               item;
  logic [ZW-1:0]                    zwork;
  logic [wtpz_pkg::STEPS_W-1:0]     steps_left;
  logic [wtpz_pkg::SCALED_W-1:0]    scaled;

  // zoom step unit: scale and round, then divide by 100 via reciprocal
  logic [wtpz_pkg::SCALED_W-1:0] scale_mul;
  logic [wtpz_pkg::SCALED_W-1:0] scaled_next;
  logic [wtpz_pkg::PROD_W-1:0]   recip_prod;

  assign scale_mul   = item.zoom_up ? wtpz_pkg::SCALED_W'(wtpz_pkg::ZOOM_IN_MUL)
                                    : wtpz_pkg::SCALED_W'(wtpz_pkg::ZOOM_OUT_MUL);
  assign scaled_next = wtpz_pkg::SCALED_W'(wtpz_pkg::SCALED_W'(zwork) * scale_mul)
                       + wtpz_pkg::SCALED_W'(wtpz_pkg::ZOOM_ROUND);
  assign recip_prod  = wtpz_pkg::PROD_W'(scaled)
                       * wtpz_pkg::PROD_W'(wtpz_pkg::RECIP);

  assign status.step_pending = (item.kind == wtpz_pkg::KIND_ZOOM) && (steps_left != '0);
  assign status.out_busy     = out_valid && !out_ready;

  // item latch and zoom loop registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item       <= in_data;
      zwork      <= zoom_level;
      steps_left <= in_data.zoom_steps;
    end
    if (cmd.mul) begin
      scaled <= scaled_next;
    end
    if (cmd.div) begin
      zwork      <= recip_prod[wtpz_pkg::RECIP_SHIFT +: ZW];
      steps_left <= steps_left - 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_window <= wtpz_pkg::WINDOW_RESET;
      tap_limit     <= wtpz_pkg::THRESH_RESET;
      pan_stride    <= wtpz_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wtpz_pkg::REG_RECENT_WINDOW: recent_window <= cfg_data[wtpz_pkg::WINDOW_W-1:0];
        wtpz_pkg::REG_TAP_LIMIT:     tap_limit     <= cfg_data[wtpz_pkg::THRESH_W-1:0];
        wtpz_pkg::REG_PAN_STRIDE:    pan_stride    <= cfg_data[wtpz_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // wheel position reduced modulo 96 and wrapped deviation from start
  logic [SW-1:0]       pos_mod;
  logic signed [7:0]   dev_raw;
  logic signed [7:0]   dev_wrap;
  logic [DW-1:0]       dev_abs;
  logic                recent;
  logic [1:0]          quadrant;
  logic                tap_ok;

  always_comb begin
    if (item.wheel_position >= wtpz_pkg::POS_W'(2 * wtpz_pkg::WHEEL_SIZE))
      pos_mod = SW'(item.wheel_position - wtpz_pkg::POS_W'(2 * wtpz_pkg::WHEEL_SIZE));
    else if (item.wheel_position >= wtpz_pkg::POS_W'(wtpz_pkg::WHEEL_SIZE))
      pos_mod = SW'(item.wheel_position - wtpz_pkg::POS_W'(wtpz_pkg::WHEEL_SIZE));
    else
      pos_mod = SW'(item.wheel_position);

    dev_raw = $signed({1'b0, pos_mod}) - $signed({1'b0, touch_start});
    if (dev_raw < -8'sd48)
      dev_wrap = dev_raw + 8'(wtpz_pkg::WHEEL_SIZE);
    else if (dev_raw > 8'(wtpz_pkg::WHEEL_HALF))
      dev_wrap = dev_raw - 8'(wtpz_pkg::WHEEL_SIZE);
    else
      dev_wrap = dev_raw;
    dev_abs = dev_wrap[7] ? DW'(-dev_wrap) : DW'(dev_wrap);

    // ignore taps shortly after a direction press (sum taken without wrap)
    recent = (direction_tick != '0) &&
             ((wtpz_pkg::NOW_W+1)'(item.now) <
              ((wtpz_pkg::NOW_W+1)'(direction_tick) + (wtpz_pkg::NOW_W+1)'(recent_window)));

    // quadrant of the start position, centered on multiples of 24
    if (touch_start < SW'(wtpz_pkg::QUAD_HALF))
      quadrant = 2'd0;
    else if (touch_start < SW'(wtpz_pkg::QUAD_HALF + wtpz_pkg::QUAD_SPAN))
      quadrant = 2'd1;
    else if (touch_start < SW'(wtpz_pkg::QUAD_HALF + 2 * wtpz_pkg::QUAD_SPAN))
      quadrant = 2'd2;
    else if (touch_start < SW'(wtpz_pkg::QUAD_HALF + 3 * wtpz_pkg::QUAD_SPAN))
      quadrant = 2'd3;
    else
      quadrant = 2'd0;

    tap_ok = start_valid && (touch_max_dev < tap_limit) && !recent;
  end

  // next viewport and touch state for the latched item
  always_comb begin
    pan_x_next           = pan_x;
    pan_y_next           = pan_y;
    zoom_level_next      = zoom_level;
    touch_active_next    = touch_active;
    start_valid_next     = start_valid;
    touch_start_next     = touch_start;
    touch_max_dev_next   = touch_max_dev;
    direction_tick_next  = direction_tick;
    pan_render_flag_next = pan_render_flag;
    case (item.kind)
      wtpz_pkg::KIND_WHEEL: begin
        if (zoom_level <= ZW'(wtpz_pkg::ZOOM_MIN)) begin
          touch_active_next = 1'b0;
        end else if (item.touched) begin
          if (!touch_active) begin
            touch_active_next  = 1'b1;
            start_valid_next   = 1'b1;
            touch_start_next   = pos_mod;
            touch_max_dev_next = '0;
          end else if (dev_abs > touch_max_dev) begin
            touch_max_dev_next = dev_abs;
          end
        end else if (touch_active) begin
          if (tap_ok) begin
            case (quadrant)
              2'd0:    pan_y_next = pan_move(pan_y, pan_stride, 1'b0);
              2'd1:    pan_x_next = pan_move(pan_x, pan_stride, 1'b0);
              2'd2:    pan_y_next = pan_move(pan_y, pan_stride, 1'b1);
              default: pan_x_next = pan_move(pan_x, pan_stride, 1'b1);
            endcase
            pan_render_flag_next = 1'b1;
          end
          touch_active_next  = 1'b0;
          start_valid_next   = 1'b0;
          touch_start_next   = '0;
          touch_max_dev_next = '0;
        end
      end
      wtpz_pkg::KIND_DIR: begin
        direction_tick_next = item.now;
      end
      wtpz_pkg::KIND_ZOOM: begin
        if (zwork < ZW'(wtpz_pkg::ZOOM_MIN))
          zoom_level_next = ZW'(wtpz_pkg::ZOOM_MIN);
        else if (zwork > ZW'(wtpz_pkg::ZOOM_MAX))
          zoom_level_next = ZW'(wtpz_pkg::ZOOM_MAX);
        else
          zoom_level_next = zwork;
        if (zoom_level_next == ZW'(wtpz_pkg::ZOOM_MIN)) begin
          pan_x_next = '0;
          pan_y_next = '0;
        end
      end
      wtpz_pkg::KIND_OPEN: begin
        pan_x_next = '0;
        pan_y_next = '0;
        if (item.open_zoom < wtpz_pkg::OPEN_W'(wtpz_pkg::ZOOM_MIN))
          zoom_level_next = ZW'(wtpz_pkg::ZOOM_MIN);
        else if (item.open_zoom > wtpz_pkg::OPEN_W'(wtpz_pkg::ZOOM_OPEN_MAX))
          zoom_level_next = ZW'(wtpz_pkg::ZOOM_OPEN_MAX);
        else
          zoom_level_next = ZW'(item.open_zoom);
        pan_render_flag_next = 1'b0;
      end
      wtpz_pkg::KIND_TAKE: begin
        pan_render_flag_next = 1'b0;
      end
      wtpz_pkg::KIND_CANCEL: begin
        touch_active_next  = 1'b0;
        start_valid_next   = 1'b0;
        touch_start_next   = '0;
        touch_max_dev_next = '0;
      end
      default: ;
    endcase
  end

  // state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_x           <= '0;
      pan_y           <= '0;
      zoom_level      <= ZW'(wtpz_pkg::ZOOM_MIN);
      touch_active    <= 1'b0;
      start_valid     <= 1'b0;
      touch_start     <= '0;
      touch_max_dev   <= '0;
      direction_tick  <= '0;
      pan_render_flag <= 1'b0;
    end else if (cmd.apply) begin
      pan_x           <= pan_x_next;
      pan_y           <= pan_y_next;
      zoom_level      <= zoom_level_next;
      touch_active    <= touch_active_next;
      start_valid     <= start_valid_next;
      touch_start     <= touch_start_next;
      touch_max_dev   <= touch_max_dev_next;
      direction_tick  <= direction_tick_next;
      pan_render_flag <= pan_render_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_data.pan_x_out      <= pan_x_next;
      out_data.pan_y_out      <= pan_y_next;
      out_data.zoom_out       <= zoom_level_next[wtpz_pkg::ZOOM_OUT_W-1:0];
      out_data.zoomed         <= zoom_level_next > ZW'(wtpz_pkg::ZOOM_MIN);
      out_data.render_pending <= (item.kind == wtpz_pkg::KIND_TAKE) ? pan_render_flag
                                                                    : pan_render_flag_next;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_wheel_tap_pan_zoom_control.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wheel_tap_pan_zoom_control
// drives wheel samples, direction presses, zoom and detail items into the
// pan/zoom controller and checks every result against a cycle-free model of
// the viewport kept in a scoreboard; directed corner cases first, then random
// tap gestures and noise under several register settings with random
// sender gaps, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------

module tb_wheel_tap_pan_zoom_control;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int RESET_CYCLES     = 6;
  localparam int DRAIN_CYCLES     = 40;
  localparam int HOLD_CYCLES      = 300;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int RANDOM_PHASES    = 4;
  localparam int PERCENT          = 100;
  localparam int PAN_MAX          = (1 << (wtpz_pkg::PAN_W - 1)) - 1;
  localparam int PAN_MIN          = -(1 << (wtpz_pkg::PAN_W - 1));
  localparam int POS_MAX          = (1 << wtpz_pkg::POS_W) - 1;
  localparam int MAX_PRINTED      = 20;

  // kinds the block leaves without effect
  localparam logic [wtpz_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [wtpz_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

  // pan direction of a tap, by wheel quadrant
  typedef enum int {
    PAN_Y_PLUS  = 0,
    PAN_X_PLUS  = 1,
    PAN_Y_MINUS = 2,
    PAN_X_MINUS = 3
  } pan_dir_t;

  // receiver stall patterns
  typedef enum int {
    RX_STEADY,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  // viewport model plus queue of expected viewport results
  class viewport_scoreboard;
    logic [wtpz_pkg::WINDOW_W-1:0] window;
    logic [wtpz_pkg::THRESH_W-1:0] thresh;
    logic [wtpz_pkg::STEP_W-1:0]   step;
    logic signed [wtpz_pkg::PAN_W-1:0] pan_x;
    logic signed [wtpz_pkg::PAN_W-1:0] pan_y;
    logic [wtpz_pkg::ZOOM_W-1:0]   zoom;
    logic                          touch_active;
    logic                          start_valid;
    logic [wtpz_pkg::START_W-1:0]  touch_start;
    logic [wtpz_pkg::DEV_W-1:0]    max_dev;
    logic [wtpz_pkg::NOW_W-1:0]    dir_tick;
    logic                          render_flag;
    wtpz_pkg::out_item_t           expected_views[$];
    int                            mismatches;
    int                            results_checked;
    int                            taps;

    function new();
      window      = wtpz_pkg::WINDOW_RESET;
      thresh      = wtpz_pkg::THRESH_RESET;
      step        = wtpz_pkg::STEP_RESET;
      pan_x       = '0;
      pan_y       = '0;
      zoom        = wtpz_pkg::ZOOM_W'(wtpz_pkg::ZOOM_MIN);
      clear_touch();
      dir_tick    = '0;
      render_flag = 1'b0;
      mismatches  = 0;
      results_checked = 0;
      taps        = 0;
    endfunction

    function void clear_touch();
      touch_active = 1'b0;
      start_valid  = 1'b0;
      touch_start  = '0;
      max_dev      = '0;
    endfunction

    function int sat_pan(int v);
      if (v > PAN_MAX) return PAN_MAX;
      if (v < PAN_MIN) return PAN_MIN;
      return v;
    endfunction

    function void set_register(logic [wtpz_pkg::CFG_INDEX_W-1:0] index,
                               logic [wtpz_pkg::CFG_DATA_W-1:0] value);
      case (index)
        wtpz_pkg::REG_RECENT_WINDOW: window = value[wtpz_pkg::WINDOW_W-1:0];
        wtpz_pkg::REG_TAP_LIMIT:     thresh = value[wtpz_pkg::THRESH_W-1:0];
        wtpz_pkg::REG_PAN_STRIDE:    step   = value[wtpz_pkg::STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the viewport by one accepted transaction
    function void note_item(wtpz_pkg::in_item_t it);
      wtpz_pkg::out_item_t          want;
      int                           pos;
      int                           travel;
      int                           z;
      int                           i;
      logic [wtpz_pkg::NOW_W:0]     window_end;
      logic                         recent;
      pan_dir_t                     dir;
      case (it.kind)
        wtpz_pkg::KIND_WHEEL: begin
          if (zoom <= wtpz_pkg::ZOOM_W'(wtpz_pkg::ZOOM_MIN)) begin
            touch_active = 1'b0;
          end else if (it.touched) begin
            pos = int'(it.wheel_position) % wtpz_pkg::WHEEL_SIZE;
            if (!touch_active) begin
              touch_active = 1'b1;
              start_valid  = 1'b1;
              touch_start  = wtpz_pkg::START_W'(pos);
              max_dev      = '0;
            end else begin
              // shortest way around the wheel from the start point
              travel = pos - int'(touch_start);
              if (travel < -wtpz_pkg::WHEEL_HALF) travel += wtpz_pkg::WHEEL_SIZE;
              else if (travel > wtpz_pkg::WHEEL_HALF) travel -= wtpz_pkg::WHEEL_SIZE;
              if (travel < 0) travel = -travel;
              if (travel > int'(max_dev)) max_dev = wtpz_pkg::DEV_W'(travel);
            end
          end else if (touch_active) begin
            // press window sum is taken one bit wider so it never wraps
            window_end = {1'b0, dir_tick}
                         + {{(wtpz_pkg::NOW_W + 1 - wtpz_pkg::WINDOW_W){1'b0}}, window};
            recent = (dir_tick != '0) && ({1'b0, it.now} < window_end);
            if (start_valid && max_dev < thresh && !recent) begin
              dir = pan_dir_t'(((int'(touch_start) + wtpz_pkg::QUAD_HALF)
                                / wtpz_pkg::QUAD_SPAN) % 4);
              case (dir)
                PAN_Y_PLUS:  pan_y = wtpz_pkg::PAN_W'(sat_pan(int'(pan_y) + int'(step)));
                PAN_X_PLUS:  pan_x = wtpz_pkg::PAN_W'(sat_pan(int'(pan_x) + int'(step)));
                PAN_Y_MINUS: pan_y = wtpz_pkg::PAN_W'(sat_pan(int'(pan_y) - int'(step)));
                default:     pan_x = wtpz_pkg::PAN_W'(sat_pan(int'(pan_x) - int'(step)));
              endcase
              render_flag = 1'b1;
              taps++;
            end
            clear_touch();
          end
        end
        wtpz_pkg::KIND_DIR: dir_tick = it.now;
        wtpz_pkg::KIND_ZOOM: begin
          z = int'(zoom);
          for (i = 0; i < int'(it.zoom_steps); i++)
            z = (z * (it.zoom_up ? wtpz_pkg::ZOOM_IN_MUL : wtpz_pkg::ZOOM_OUT_MUL)
                 + wtpz_pkg::ZOOM_ROUND) / PERCENT;
          if (z < wtpz_pkg::ZOOM_MIN) z = wtpz_pkg::ZOOM_MIN;
          if (z > wtpz_pkg::ZOOM_MAX) z = wtpz_pkg::ZOOM_MAX;
          zoom = wtpz_pkg::ZOOM_W'(z);
          if (z == wtpz_pkg::ZOOM_MIN) begin
            pan_x = '0;
            pan_y = '0;
          end
        end
        wtpz_pkg::KIND_OPEN: begin
          z = int'(it.open_zoom);
          if (z < wtpz_pkg::ZOOM_MIN) z = wtpz_pkg::ZOOM_MIN;
          if (z > wtpz_pkg::ZOOM_OPEN_MAX) z = wtpz_pkg::ZOOM_OPEN_MAX;
          zoom        = wtpz_pkg::ZOOM_W'(z);
          pan_x       = '0;
          pan_y       = '0;
          render_flag = 1'b0;
        end
        wtpz_pkg::KIND_CANCEL: clear_touch();
        default: ;
      endcase
      want.pan_x_out      = pan_x;
      want.pan_y_out      = pan_y;
      want.zoom_out       = zoom[wtpz_pkg::ZOOM_OUT_W-1:0];
      want.zoomed         = zoom > wtpz_pkg::ZOOM_W'(wtpz_pkg::ZOOM_MIN);
      want.render_pending = render_flag;
      // take reports the flag and then drops it
      if (it.kind == wtpz_pkg::KIND_TAKE) render_flag = 1'b0;
      expected_views.push_back(want);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task check_view(wtpz_pkg::out_item_t got);
      wtpz_pkg::out_item_t want;
      if (expected_views.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = expected_views.pop_front();
      results_checked++;
      if (got.pan_x_out !== want.pan_x_out)
        report($sformatf("result %0d: pan_x_out %0d, expected %0d",
                         results_checked, got.pan_x_out, want.pan_x_out));
      if (got.pan_y_out !== want.pan_y_out)
        report($sformatf("result %0d: pan_y_out %0d, expected %0d",
                         results_checked, got.pan_y_out, want.pan_y_out));
      if (got.zoom_out !== want.zoom_out)
        report($sformatf("result %0d: zoom_out %0d, expected %0d",
                         results_checked, got.zoom_out, want.zoom_out));
      if (got.zoomed !== want.zoomed)
        report($sformatf("result %0d: zoomed %b, expected %b",
                         results_checked, got.zoomed, want.zoomed));
      if (got.render_pending !== want.render_pending)
        report($sformatf("result %0d: render_pending %b, expected %b",
                         results_checked, got.render_pending, want.render_pending));
    endtask

    task flush_leftovers();
      while (expected_views.size() != 0)
        report($sformatf("expected result %h never arrived", expected_views.pop_front()));
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  wtpz_pkg::in_item_t               in_data;
  logic                             out_valid;
  logic                             out_ready;
  wtpz_pkg::out_item_t              out_data;
  logic                             cfg_we;
  logic [wtpz_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wtpz_pkg::CFG_DATA_W-1:0]  cfg_data;

  viewport_scoreboard sb = new();
  int                 cycle_count;
  int                 items_sent;
  int                 burst_left;
  int                 holds_requested;
  int                 holds_done;
  int                 settings_used;
  logic [wtpz_pkg::NOW_W-1:0]    tick;
  logic [wtpz_pkg::THRESH_W-1:0] cur_thresh;
  int                 pref_quad;

  wheel_tap_pan_zoom_control uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, sb.expected_views.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // transaction monitor: values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_view(out_data);
      if (in_valid && in_ready) sb.note_item(in_data);
    end
  end

  // receiver: changing stall patterns plus long hold-offs on request
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    mode      = RX_STEADY;
    mode_left = 0;
    hold_left = 0;
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_requested) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_LIGHT:  out_ready <= ($urandom_range(0, 99) < 70);
          RX_HEAVY:  out_ready <= ($urandom_range(0, 99) < 20);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // offer one transaction and wait for it to be taken, sender idles between bursts
  task automatic offer(input wtpz_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // fields a kind does not use carry random bits
  function automatic wtpz_pkg::in_item_t make_item(input logic [wtpz_pkg::KIND_W-1:0] kind);
    wtpz_pkg::in_item_t it;
    it.kind           = kind;
    it.touched        = 1'($urandom);
    it.wheel_position = 8'($urandom);
    it.now            = $urandom;
    it.zoom_up        = 1'($urandom);
    it.zoom_steps     = 4'($urandom);
    it.open_zoom      = 10'($urandom);
    return it;
  endfunction

  task automatic send_sample(input logic touched, input logic [wtpz_pkg::POS_W-1:0] pos,
                             input logic [wtpz_pkg::NOW_W-1:0] now);
    wtpz_pkg::in_item_t it;
    it = make_item(wtpz_pkg::KIND_WHEEL);
    it.touched        = touched;
    it.wheel_position = pos;
    it.now            = now;
    offer(it);
  endtask

  task automatic send_press(input logic [wtpz_pkg::NOW_W-1:0] now);
    wtpz_pkg::in_item_t it;
    it = make_item(wtpz_pkg::KIND_DIR);
    it.now = now;
    offer(it);
  endtask

  task automatic send_zoom(input logic up, input logic [wtpz_pkg::STEPS_W-1:0] steps);
    wtpz_pkg::in_item_t it;
    it = make_item(wtpz_pkg::KIND_ZOOM);
    it.zoom_up    = up;
    it.zoom_steps = steps;
    offer(it);
  endtask

  task automatic send_open(input logic [wtpz_pkg::OPEN_W-1:0] z);
    wtpz_pkg::in_item_t it;
    it = make_item(wtpz_pkg::KIND_OPEN);
    it.open_zoom = z;
    offer(it);
  endtask

  task automatic send_kind(input logic [wtpz_pkg::KIND_W-1:0] kind);
    offer(make_item(kind));
  endtask

  // stop offering and wait until every result is back and the block is idle
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_registers(input logic [wtpz_pkg::WINDOW_W-1:0] window,
                                 input logic [wtpz_pkg::THRESH_W-1:0] thresh,
                                 input logic [wtpz_pkg::STEP_W-1:0] step);
    cfg_we    <= 1'b1;
    cfg_index <= wtpz_pkg::REG_RECENT_WINDOW;
    cfg_data  <= window;
    @(posedge clk);
    cfg_index <= wtpz_pkg::REG_TAP_LIMIT;
    cfg_data  <= {{(wtpz_pkg::CFG_DATA_W - wtpz_pkg::THRESH_W){1'b0}}, thresh};
    @(posedge clk);
    cfg_index <= wtpz_pkg::REG_PAN_STRIDE;
    cfg_data  <= {{(wtpz_pkg::CFG_DATA_W - wtpz_pkg::STEP_W){1'b0}}, step};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(wtpz_pkg::REG_RECENT_WINDOW, window);
    sb.set_register(wtpz_pkg::REG_TAP_LIMIT,
                    {{(wtpz_pkg::CFG_DATA_W - wtpz_pkg::THRESH_W){1'b0}}, thresh});
    sb.set_register(wtpz_pkg::REG_PAN_STRIDE,
                    {{(wtpz_pkg::CFG_DATA_W - wtpz_pkg::STEP_W){1'b0}}, step});
    cur_thresh = thresh;
    settings_used++;
  endtask

  function automatic logic [wtpz_pkg::NOW_W-1:0] next_tick();
    tick += wtpz_pkg::NOW_W'($urandom_range(1, 300));
    return tick;
  endfunction

  // any raw wheel reading that reduces to position p
  function automatic logic [wtpz_pkg::POS_W-1:0] raw_position(input int p);
    int r;
    r = p + wtpz_pkg::WHEEL_SIZE * int'($urandom_range(0, 2));
    if (r > POS_MAX) r -= wtpz_pkg::WHEEL_SIZE;
    return wtpz_pkg::POS_W'(r);
  endfunction

  // touch down, a few moves, release; a broken one is cancelled before release
  task automatic tap_gesture(input logic broken);
    int start;
    int moves;
    int spread;
    int delta;
    if ($urandom_range(0, 1) == 1)
      start = (pref_quad * wtpz_pkg::QUAD_SPAN
               + int'($urandom_range(0, wtpz_pkg::QUAD_SPAN - 1)) - wtpz_pkg::QUAD_HALF
               + wtpz_pkg::WHEEL_SIZE) % wtpz_pkg::WHEEL_SIZE;
    else
      start = int'($urandom_range(0, wtpz_pkg::WHEEL_SIZE - 1));
    send_sample(1'b1, raw_position(start), next_tick());
    moves  = $urandom_range(0, 3);
    spread = ($urandom_range(0, 9) < 7) ? int'(cur_thresh) : wtpz_pkg::WHEEL_HALF;
    repeat (moves) begin
      delta = int'($urandom_range(0, spread));
      if ($urandom_range(0, 1) == 1) delta = -delta;
      send_sample(1'b1,
                  raw_position((start + delta + wtpz_pkg::WHEEL_SIZE) % wtpz_pkg::WHEEL_SIZE),
                  next_tick());
    end
    if (broken) send_kind(wtpz_pkg::KIND_CANCEL);
    send_sample(1'b0, 8'($urandom), next_tick());
  endtask

  task automatic random_activity();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      tap_gesture(1'b0);
    end else if (roll < 60) begin
      tap_gesture(1'b1);
    end else if (roll < 68) begin
      send_press(next_tick());
      if ($urandom_range(0, 1) == 1) tap_gesture(1'b0);
    end else if (roll < 76) begin
      send_zoom($urandom_range(0, 99) < 75, 4'($urandom));
    end else if (roll < 80) begin
      if ($urandom_range(0, 99) < 85)
        send_open(10'($urandom_range(wtpz_pkg::ZOOM_MIN + 1, wtpz_pkg::ZOOM_OPEN_MAX)));
      else send_open(10'($urandom));
    end else if (roll < 90) begin
      send_kind(wtpz_pkg::KIND_TAKE);
    end else if (roll < 93) begin
      send_kind(wtpz_pkg::KIND_CANCEL);
    end else begin
      // noise with every field random
      send_kind(3'($urandom));
    end
  endtask

  // main stimulus
  initial begin : stimulus
    logic [wtpz_pkg::WINDOW_W-1:0] win;
    logic [wtpz_pkg::THRESH_W-1:0] thr;
    logic [wtpz_pkg::STEP_W-1:0]   stp;
    int                            phase;
    int                            phase_start;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    items_sent  = 0;
    burst_left  = 0;
    holds_requested = 0;
    settings_used   = 0;
    tick        = '0;
    cur_thresh  = wtpz_pkg::THRESH_RESET;
    pref_quad   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset register values
    send_sample(1'b1, 8'd10, 32'd100);   // not zoomed, touch dropped
    send_sample(1'b0, 8'd10, 32'd101);   // release with no touch
    send_zoom(1'b1, 4'd0);               // zero steps, clamp only
    send_zoom(1'b1, 4'd15);
    send_sample(1'b1, 8'd0, 32'd200);    // first touch records start
    send_sample(1'b1, 8'd2, 32'd201);
    send_sample(1'b0, 8'd0, 32'd202);    // short tap, pans y up
    send_kind(wtpz_pkg::KIND_TAKE);
    send_sample(1'b1, 8'd255, 32'd300);  // reduces to 63, last quadrant
    send_sample(1'b0, 8'd255, 32'd301);
    send_sample(1'b1, 8'd95, 32'd310);   // quadrant wraps back to the first
    send_sample(1'b1, 8'd143, 32'd311);  // half way round the wheel
    send_sample(1'b0, 8'd95, 32'd312);   // moved too far, no tap
    send_sample(1'b1, 8'd30, 32'd320);
    send_kind(wtpz_pkg::KIND_CANCEL);
    send_sample(1'b0, 8'd30, 32'd321);   // release after cancel
    send_kind(KIND_SPARE_A);
    send_kind(KIND_SPARE_B);
    send_open(10'd0);                    // raised to the minimum zoom
    send_zoom(1'b0, 4'd15);              // stays at minimum, pan cleared
    send_open(10'd1023);                 // capped at the open maximum
    send_zoom(1'b0, 4'd15);              // clamped down to zoom maximum

    // directed: widest window, threshold and step
    settle();
    write_registers(16'hFFFF, 6'd48, 10'd1023);
    send_press(32'hFFFF_FF00);
    send_sample(1'b1, 8'd40, 32'hFFFF_FF10);
    send_sample(1'b1, 8'd87, 32'hFFFF_FF20);
    send_sample(1'b0, 8'd40, 32'hFFFF_FFFF);  // press window runs past 32 bits
    send_press(32'd0);                          // a zero press never blocks
    send_sample(1'b1, 8'd40, 32'd5);
    send_sample(1'b1, 8'd87, 32'd6);
    send_sample(1'b0, 8'd40, 32'd7);            // deviation just under threshold

    // random: one register setting per phase
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin win = 16'd300;   thr = 6'd6;  stp = 10'd32;   end
        1: begin win = 16'd0;     thr = 6'd0;  stp = 10'd0;    end
        2: begin win = 16'hFFFF;  thr = 6'd48; stp = 10'd1023; end
        default: begin
          win = 16'($urandom);
          thr = 6'($urandom_range(1, wtpz_pkg::WHEEL_HALF));
          stp = 10'($urandom);
        end
      endcase
      write_registers(win, thr, stp);
      tick      = $urandom;
      pref_quad = $urandom_range(0, 3);
      if (phase == 0) holds_requested++;
      send_open(10'($urandom_range(wtpz_pkg::ZOOM_MIN + 1, wtpz_pkg::ZOOM_OPEN_MAX)));
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_PER_PHASE) random_activity();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_leftovers();
    $display("covered %0d transactions and %0d results under %0d register settings",
             items_sent, sb.results_checked, settings_used);
    $display("%0d taps panned the view, %0d mismatches", sb.taps, sb.mismatches);
    if (sb.mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
